// File: hw/rtl/spq_pkg.sv
// Package for the sorted priority queue: field widths, operation and status
// codes, cell shift modes and the structs passed from control to the cells.
// No dependencies.
`default_nettype none

package spq_pkg;

  localparam int FUNC_W   = 2;
  localparam int STATE_W  = 16;
  localparam int COST_W   = 32;
  localparam int STATUS_W = 2;

  localparam int DEF_CAPACITY   = 64;
  localparam int DEF_STATE_BITS = 16;
  localparam int DEF_COUNT_W    = $clog2(DEF_CAPACITY + 1);

  localparam logic [FUNC_W-1:0] FUNC_PUSH   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd3;

  // shift modes applied to every cell in the update cycle
  localparam int MODE_W = 3;
  localparam logic [MODE_W-1:0] MODE_KEEP = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INS  = 3'd1;  // insert at p, shift up above p
  localparam logic [MODE_W-1:0] MODE_POP  = 3'd2;  // everything moves down one
  localparam logic [MODE_W-1:0] MODE_FWD  = 3'd3;  // move entry q down to p (p < q)
  localparam logic [MODE_W-1:0] MODE_BACK = 3'd4;  // move entry q up to p-1 (p > q)

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [COST_W-1:0] key_cost;
  } cell_ctl_t;

  typedef struct packed {
    logic ge_p;        // slot index >= p
    logic gt_p;        // slot index >  p
    logic ge_p_right;  // slot index + 1 >= p
    logic ge_q;        // slot index >= q
    logic gt_q;        // slot index >  q
  } cell_flags_t;

endpackage

`default_nettype wire

// File: hw/rtl/spq_if.sv
// Handshake channels of the sorted priority queue: operation in, result out.
// Depends on spq_pkg.
`default_nettype none

interface spq_in_if import spq_pkg::*;;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [STATE_W-1:0]  state_id;
  logic [COST_W-1:0]   cost;

  modport source (output valid, func, state_id, cost, input ready);
  modport sink   (input valid, func, state_id, cost, output ready);
endinterface

// COUNT_W must equal $clog2(CAPACITY + 1) of the queue it connects to
interface spq_out_if import spq_pkg::*; #(parameter int COUNT_W = DEF_COUNT_W);
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [STATE_W-1:0]  out_state;
  logic [COST_W-1:0]   out_cost;
  logic [COUNT_W-1:0]  occupancy;

  modport source (output valid, status, out_state, out_cost, occupancy, input ready);
  modport sink   (input valid, status, out_state, out_cost, occupancy, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/spq_cell.sv
// One slot of the sorted queue: holds a (state, cost) entry, compares it with
// the key and takes its own, its neighbours' or the new entry. Uses spq_pkg.
`default_nettype none

module spq_cell import spq_pkg::*; #(
  parameter int STATE_BITS = DEF_STATE_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  cmp_en,
  input  wire logic                  upd_en,
  input  wire cell_ctl_t             ctl,
  input  wire cell_flags_t           flags,
  input  wire logic [STATE_BITS-1:0] key_state,
  input  wire logic [STATE_BITS-1:0] left_state,
  input  wire logic [COST_W-1:0]     left_cost,
  input  wire logic [STATE_BITS-1:0] right_state,
  input  wire logic [COST_W-1:0]     right_cost,
  output logic      [STATE_BITS-1:0] state,
  output logic      [COST_W-1:0]     cost,
  output logic                       ge_hit,
  output logic                       eq_hit
);

  logic take_new;
  logic take_left;
  logic take_right;

  always_comb begin
    take_new   = 1'b0;
    take_left  = 1'b0;
    take_right = 1'b0;
    case (ctl.mode)
      MODE_INS: begin
        take_new  = flags.ge_p & ~flags.gt_p;
        take_left = flags.gt_p;
      end
      MODE_POP: begin
        take_right = 1'b1;
      end
      MODE_FWD: begin
        take_new  = flags.ge_p & ~flags.gt_p;
        take_left = flags.gt_p & ~flags.gt_q;
      end
      MODE_BACK: begin
        take_new   = flags.ge_p_right & ~flags.ge_p;
        take_right = flags.ge_q & ~flags.ge_p_right;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmp_en) begin
      ge_hit <= (cost >= ctl.key_cost);
      eq_hit <= (state == key_state);
    end
    if (upd_en) begin
      if (take_new) begin
        state <= key_state;
        cost  <= ctl.key_cost;
      end else if (take_left) begin
        state <= left_state;
        cost  <= left_cost;
      end else if (take_right) begin
        state <= right_state;
        cost  <= right_cost;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: operation sequencer, slot search
// and a row of spq_cell slots. Uses spq_pkg, spq_in_if, spq_out_if.
//
//   channel  dir  fields                                  handshake
//   in_ch    in   func, state_id, cost                    valid/ready
//   out_ch   out  status, out_state, out_cost, occupancy  valid/ready
//
// Per item, a compare state, then an update state: every slot compares its
// entry with the key, then the first-match and insert positions are found
// across the row and all slots shift at once as the next item may be taken.
// Reset clears the entry count and the handshake; slot contents need none.
// A result not yet taken holds the shift cycle until out_ch is free.
`default_nettype none

module sorted_priority_queue import spq_pkg::*; #(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int STATE_BITS = DEF_STATE_BITS
) (
  input wire logic clk,
  input wire logic rst,
  spq_in_if.sink   in_ch,
  spq_out_if.source out_ch
);

  localparam int COUNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0]            state;
  logic [FUNC_W-1:0]     func_q;
  logic [STATE_BITS-1:0] key_state;
  logic [COST_W-1:0]     key_cost;
  logic [COUNT_W-1:0]    count;
  logic [COUNT_W-1:0]    count_next;

  logic [STATE_BITS-1:0] cell_state [CAPACITY];
  logic [COST_W-1:0]     cell_cost  [CAPACITY];
  logic [CAPACITY-1:0]   ge_hit, eq_hit;
  logic [CAPACITY-1:0]   occ, ge_v, eq_v, isq, geq, gp, gep, isp;
  cell_flags_t           flags [CAPACITY];
  cell_ctl_t             ctl;

  logic                  adv, take_in, full, empty, present, p_lt_q;
  logic [MODE_W-1:0]     mode;
  logic [STATUS_W-1:0]   status_next;
  logic [STATE_BITS-1:0] res_state, sel_state;
  logic [COST_W-1:0]     res_cost, sel_cost;

  assign adv     = (state == ST_UPD) && (!out_ch.valid || out_ch.ready);
  assign take_in = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == ST_IDLE) || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      if (take_in) begin
        state <= ST_CMP;
      end else if (state == ST_CMP) begin
        state <= ST_UPD;
      end else if (adv) begin
        state <= ST_IDLE;
      end
      if (adv) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      func_q    <= in_ch.func;
      key_state <= STATE_BITS'(in_ch.state_id);
      key_cost  <= in_ch.cost;
    end
  end

  // search vectors: x | -x marks every slot from the lowest set bit upward
  assign ge_v    = ge_hit & occ;
  assign eq_v    = eq_hit & occ;
  assign isq     = eq_v & (~eq_v + CAPACITY'(1));
  assign geq     = eq_v | (~eq_v + CAPACITY'(1));
  assign present = |eq_v;
  // only an update leaves its own matching entry out of the insert search
  assign gp      = (ge_v & ~(isq & {CAPACITY{func_q == FUNC_UPDATE}})) | ~occ;
  assign gep     = gp | (~gp + CAPACITY'(1));
  assign isp     = gep & ~{gep[CAPACITY-2:0], 1'b0};
  assign p_lt_q  = |(isp & ~geq);
  assign full    = (count == COUNT_W'(CAPACITY));
  assign empty   = (count == '0);

  always_comb begin
    sel_state = '0;
    sel_cost  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_state = sel_state | (cell_state[i] & {STATE_BITS{isq[i]}});
      sel_cost  = sel_cost  | (cell_cost[i]  & {COST_W{isq[i]}});
    end
  end

  always_comb begin
    mode        = MODE_KEEP;
    status_next = STATUS_OK;
    res_state   = '0;
    res_cost    = '0;
    count_next  = count;
    case (func_q)
      FUNC_PUSH: begin
        if (full) begin
          status_next = STATUS_FULL;
        end else begin
          mode       = MODE_INS;
          count_next = count + COUNT_W'(1);
        end
      end
      FUNC_POP: begin
        if (empty) begin
          status_next = STATUS_EMPTY;
        end else begin
          mode       = MODE_POP;
          res_state  = cell_state[0];
          res_cost   = cell_cost[0];
          count_next = count - COUNT_W'(1);
        end
      end
      FUNC_UPDATE: begin
        if (present) begin
          mode = p_lt_q ? MODE_FWD : MODE_BACK;
        end else if (full) begin
          status_next = STATUS_FULL;
        end else begin
          mode       = MODE_INS;
          count_next = count + COUNT_W'(1);
        end
      end
      FUNC_FIND: begin
        if (present) begin
          res_state = sel_state;
          res_cost  = sel_cost;
        end else begin
          status_next = STATUS_MISSING;
        end
      end
      default: begin
      end
    endcase
  end

  assign ctl.mode     = mode;
  assign ctl.key_cost = key_cost;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [STATE_BITS-1:0] l_state, r_state;
    logic [COST_W-1:0]     l_cost, r_cost;

    assign occ[i] = (COUNT_W'(i) < count);

    if (i == 0) begin : g_first
      assign l_state     = '0;
      assign l_cost      = '0;
      assign flags[i].gt_p = 1'b0;
      assign flags[i].gt_q = 1'b0;
    end else begin : g_mid
      assign l_state     = cell_state[i-1];
      assign l_cost      = cell_cost[i-1];
      assign flags[i].gt_p = gep[i-1];
      assign flags[i].gt_q = geq[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign r_state           = '0;
      assign r_cost            = '0;
      assign flags[i].ge_p_right = 1'b1;
    end else begin : g_low
      assign r_state           = cell_state[i+1];
      assign r_cost            = cell_cost[i+1];
      assign flags[i].ge_p_right = gep[i+1];
    end

    assign flags[i].ge_p = gep[i];
    assign flags[i].ge_q = geq[i];

    spq_cell #(
      .STATE_BITS (STATE_BITS)
    ) u_cell (
      .clk         (clk),
      .cmp_en      (state == ST_CMP),
      .upd_en      (adv),
      .ctl         (ctl),
      .flags       (flags[i]),
      .key_state   (key_state),
      .left_state  (l_state),
      .left_cost   (l_cost),
      .right_state (r_state),
      .right_cost  (r_cost),
      .state       (cell_state[i]),
      .cost        (cell_cost[i]),
      .ge_hit      (ge_hit[i]),
      .eq_hit      (eq_hit[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (adv) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch.status    <= status_next;
      out_ch.out_state <= STATE_W'(res_state);
      out_ch.out_cost  <= res_cost;
      out_ch.occupancy <= COUNT_W'(count_next);
    end
  end

`ifndef ASSERT_OFF
  a_one_match: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD) |-> $onehot0(isq))
    else $error("more than one first match");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_cmp_upd: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP) |=> (state == ST_UPD))
    else $error("compare cycle not followed by update");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (adv && mode == MODE_POP) |=> (count == $past(count) - COUNT_W'(1)))
    else $error("pop did not drop the count");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD && !adv) |=> ($stable(count) && state == ST_UPD))
    else $error("queue changed while result stalled");
`endif

endmodule

`default_nettype wire
